>>> rtl/core/arp_pkg.sv
// Shared constants, types and helper functions for the ARP frame responder.
package arp_pkg;

  localparam int unsigned FrameMinLen = 42;
  localparam int unsigned PosWidth    = 6;

  localparam logic [15:0] EthTypeArp  = 16'h0806;
  localparam logic [15:0] OpRequest   = 16'h0001;
  localparam logic [15:0] OpReply     = 16'h0002;
  localparam logic [7:0]  BcastByte   = 8'hFF;

  localparam logic [PosWidth-1:0] PosEthType0 = 6'd12;
  localparam logic [PosWidth-1:0] PosEthType1 = 6'd13;
  localparam logic [PosWidth-1:0] PosFixed    = 6'd14;
  localparam logic [PosWidth-1:0] PosOpcode0  = 6'd20;
  localparam logic [PosWidth-1:0] PosOpcode1  = 6'd21;
  localparam logic [PosWidth-1:0] PosSndMac   = 6'd22;
  localparam logic [PosWidth-1:0] PosSndIp    = 6'd28;
  localparam logic [PosWidth-1:0] PosTgtMac   = 6'd32;
  localparam logic [PosWidth-1:0] PosTgtIp    = 6'd38;
  localparam logic [PosWidth-1:0] PosEnd      = 6'd42;
  localparam logic [PosWidth-1:0] PosSrcMac   = 6'd6;

  localparam logic [1:0] VerdictIgnored = 2'd0;
  localparam logic [1:0] VerdictRequest = 2'd1;
  localparam logic [1:0] VerdictReply   = 2'd2;

  localparam logic KindStatus = 1'b0;
  localparam logic KindTx     = 1'b1;

  localparam logic RegOwnMac = 1'b0;
  localparam logic RegOwnIp  = 1'b1;

  typedef struct packed {
    logic [1:0]  verdict;
    logic [47:0] peer_mac;
    logic [31:0] peer_ip;
    logic        cache_valid;
    logic [31:0] cache_ip;
    logic [47:0] cache_mac;
  } frame_evt_t;

  // ARP fixed header: hardware type, protocol type, hardware and protocol lengths
  function automatic logic [7:0] fixed_hdr_byte(logic [2:0] k);
    logic [7:0] b;
    case (k)
      3'd0:    b = 8'h00;
      3'd1:    b = 8'h01;
      3'd2:    b = 8'h08;
      3'd3:    b = 8'h00;
      3'd4:    b = 8'h06;
      3'd5:    b = 8'h04;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] mac_byte(logic [47:0] v, logic [2:0] k);
    logic [7:0] b;
    case (k)
      3'd0:    b = v[47:40];
      3'd1:    b = v[39:32];
      3'd2:    b = v[31:24];
      3'd3:    b = v[23:16];
      3'd4:    b = v[15:8];
      3'd5:    b = v[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] ip_byte(logic [31:0] v, logic [1:0] k);
    logic [7:0] b;
    case (k)
      2'd0:    b = v[31:24];
      2'd1:    b = v[23:16];
      2'd2:    b = v[15:8];
      default: b = v[7:0];
    endcase
    return b;
  endfunction

endpackage

>>> rtl/core/arp_frame_responder.sv
// ARP responder: frame byte capture, validation, single-entry cache and reply emitter.
// A last byte's event is registered in the pending slot, then in the active slot, where
// its status item comes first. Throughput: one received byte per cycle; input stalls
// while a queued event waits on a busy emitter. An answered request yields a status item
// and 42 reply bytes, any other frame end a status item alone.
// Reset (async, active low) clears capture state, the cache, the queue and the emitter;
// own_mac and own_ip reset to zero.
module arp_frame_responder
  import arp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [47:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        rx_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        item_kind_o,
  output logic [7:0]  tx_byte_o,
  output logic        run_last_o,
  output logic [1:0]  verdict_o,
  output logic        cache_valid_o,
  output logic [31:0] cache_ip_o,
  output logic [47:0] cache_mac_o
);

  logic [47:0] own_mac_q;
  logic [31:0] own_ip_q;

  logic [PosWidth-1:0] pos_q, pos_d;
  logic [15:0] ethtype_q, ethtype_d;
  logic        fixed_ok_q, fixed_ok_d;
  logic [15:0] opcode_q, opcode_d;
  logic [47:0] peer_mac_q, peer_mac_d;
  logic [31:0] peer_ip_q, peer_ip_d;
  logic        tgt_ok_q, tgt_ok_d;

  logic        entry_valid_q;
  logic [31:0] entry_ip_q;
  logic [47:0] entry_mac_q;

  logic       pend_valid_q;
  frame_evt_t pend_q;
  logic       act_valid_q;
  frame_evt_t act_q;
  logic [PosWidth-1:0] cnt_q;

  logic       in_acc, out_acc, frame_ok, act_done, act_load;
  logic [1:0] verdict_d;
  frame_evt_t evt_d;
  logic [PosWidth-1:0] off, idx, tx_off;

  assign in_stall_o = pend_valid_q & ~act_load;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign out_acc    = act_valid_q & ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_mac_q <= '0;
      own_ip_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegOwnMac: own_mac_q <= cfg_data_i;
        RegOwnIp:  own_ip_q  <= cfg_data_i[31:0];
        default:   ;
      endcase
    end
  end

  // byte capture
  always_comb begin
    pos_d      = pos_q;
    ethtype_d  = ethtype_q;
    fixed_ok_d = fixed_ok_q;
    opcode_d   = opcode_q;
    peer_mac_d = peer_mac_q;
    peer_ip_d  = peer_ip_q;
    tgt_ok_d   = tgt_ok_q;
    off        = '0;
    if (pos_q < PosEnd) begin
      pos_d = pos_q + 1'b1;
      if (pos_q == PosEthType0 || pos_q == PosEthType1) begin
        ethtype_d = {ethtype_q[7:0], rx_byte_i};
      end else if (pos_q >= PosFixed && pos_q < PosOpcode0) begin
        off = pos_q - PosFixed;
        if (rx_byte_i != fixed_hdr_byte(off[2:0])) fixed_ok_d = 1'b0;
      end else if (pos_q == PosOpcode0 || pos_q == PosOpcode1) begin
        opcode_d = {opcode_q[7:0], rx_byte_i};
      end else if (pos_q >= PosSndMac && pos_q < PosSndIp) begin
        peer_mac_d = {peer_mac_q[39:0], rx_byte_i};
      end else if (pos_q >= PosSndIp && pos_q < PosTgtMac) begin
        peer_ip_d = {peer_ip_q[23:0], rx_byte_i};
      end else if (pos_q >= PosTgtIp) begin
        off = pos_q - PosTgtIp;
        if (rx_byte_i != ip_byte(own_ip_q, off[1:0])) tgt_ok_d = 1'b0;
      end
    end
  end

  assign frame_ok = (pos_d == PosEnd) && (ethtype_d == EthTypeArp) && fixed_ok_d &&
                    tgt_ok_d && (opcode_d == OpRequest || opcode_d == OpReply);

  always_comb begin
    verdict_d = VerdictIgnored;
    if (frame_ok) verdict_d = (opcode_d == OpRequest) ? VerdictRequest : VerdictReply;
    evt_d.verdict     = verdict_d;
    evt_d.peer_mac    = peer_mac_d;
    evt_d.peer_ip     = peer_ip_d;
    evt_d.cache_valid = frame_ok ? 1'b1 : entry_valid_q;
    evt_d.cache_ip    = frame_ok ? peer_ip_d : entry_ip_q;
    evt_d.cache_mac   = frame_ok ? peer_mac_d : entry_mac_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q         <= '0;
      ethtype_q     <= '0;
      fixed_ok_q    <= 1'b1;
      opcode_q      <= '0;
      peer_mac_q    <= '0;
      peer_ip_q     <= '0;
      tgt_ok_q      <= 1'b1;
      entry_valid_q <= 1'b0;
      entry_ip_q    <= '0;
      entry_mac_q   <= '0;
    end else if (in_acc) begin
      if (rx_last_i) begin
        pos_q      <= '0;
        ethtype_q  <= '0;
        fixed_ok_q <= 1'b1;
        opcode_q   <= '0;
        peer_mac_q <= '0;
        peer_ip_q  <= '0;
        tgt_ok_q   <= 1'b1;
        if (frame_ok) begin
          entry_valid_q <= 1'b1;
          entry_ip_q    <= peer_ip_d;
          entry_mac_q   <= peer_mac_d;
        end
      end else begin
        pos_q      <= pos_d;
        ethtype_q  <= ethtype_d;
        fixed_ok_q <= fixed_ok_d;
        opcode_q   <= opcode_d;
        peer_mac_q <= peer_mac_d;
        peer_ip_q  <= peer_ip_d;
        tgt_ok_q   <= tgt_ok_d;
      end
    end
  end

  // one-deep event queue ahead of the emitter
  assign act_done = out_acc && run_last_o;
  assign act_load = pend_valid_q && (!act_valid_q || act_done);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
    end else if (in_acc && rx_last_i) begin
      pend_valid_q <= 1'b1;
    end else if (act_load) begin
      pend_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && rx_last_i) pend_q <= evt_d;
    if (act_load) act_q <= pend_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else if (act_load) begin
      act_valid_q <= 1'b1;
      cnt_q       <= '0;
    end else if (act_done) begin
      act_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else if (out_acc) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  // reply frame byte select
  always_comb begin
    idx       = cnt_q - 1'b1;
    tx_off    = '0;
    tx_byte_o = '0;
    if (cnt_q != '0) begin
      if (idx < PosSrcMac) begin
        tx_byte_o = BcastByte;
      end else if (idx < PosEthType0) begin
        tx_off    = idx - PosSrcMac;
        tx_byte_o = mac_byte(own_mac_q, tx_off[2:0]);
      end else if (idx == PosEthType0) begin
        tx_byte_o = EthTypeArp[15:8];
      end else if (idx == PosEthType1) begin
        tx_byte_o = EthTypeArp[7:0];
      end else if (idx < PosOpcode0) begin
        tx_off    = idx - PosFixed;
        tx_byte_o = fixed_hdr_byte(tx_off[2:0]);
      end else if (idx == PosOpcode0) begin
        tx_byte_o = OpReply[15:8];
      end else if (idx == PosOpcode1) begin
        tx_byte_o = OpReply[7:0];
      end else if (idx < PosSndIp) begin
        tx_off    = idx - PosSndMac;
        tx_byte_o = mac_byte(own_mac_q, tx_off[2:0]);
      end else if (idx < PosTgtMac) begin
        tx_off    = idx - PosSndIp;
        tx_byte_o = ip_byte(own_ip_q, tx_off[1:0]);
      end else if (idx < PosTgtIp) begin
        tx_off    = idx - PosTgtMac;
        tx_byte_o = mac_byte(act_q.peer_mac, tx_off[2:0]);
      end else begin
        tx_off    = idx - PosTgtIp;
        tx_byte_o = ip_byte(act_q.peer_ip, tx_off[1:0]);
      end
    end
  end

  assign out_valid_o   = act_valid_q;
  assign item_kind_o   = (cnt_q == '0) ? KindStatus : KindTx;
  assign run_last_o    = (cnt_q == '0) ? (act_q.verdict != VerdictRequest) : (cnt_q == PosEnd);
  assign verdict_o     = act_q.verdict;
  assign cache_valid_o = act_q.cache_valid;
  assign cache_ip_o    = act_q.cache_ip;
  assign cache_mac_o   = act_q.cache_mac;

endmodule
